// ----- hw/rtl/fnmf_pkg.sv -----
package fnmf_pkg;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int WIDTH_REG_W  = 6;
  localparam int HEIGHT_REG_W = 10;
  localparam int ROW_W        = 10;
  localparam int COL_OUT_W    = 5;
  localparam int SMOOTH_W     = 8;
  localparam int OUT_DATA_W   = 24;
  localparam int OUT_PAD_W    = OUT_DATA_W - SMOOTH_W - ROW_W - COL_OUT_W;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 6'd5;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 10'd5;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = 6'd2;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = 10'd2;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } fnmf_reg_t;

  typedef enum logic [1:0] {
    DIV_2,
    DIV_3,
    DIV_4
  } fnmf_div_t;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    restart;
  } fnmf_cfg_t;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic                 has_up;
    logic                 has_down;
    logic                 has_left;
    logic                 has_right;
    fnmf_div_t            div;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } fnmf_tag_t;

endpackage

// ----- hw/rtl/fnmf_ram.sv -----
module fnmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem_r[raddr_a];
      rd_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// ----- hw/rtl/fnmf_regs.sv -----
module fnmf_regs
  import fnmf_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output fnmf_cfg_t             cfg
);

  localparam logic [WIDTH_REG_W-1:0] WIDTH_MAX = WIDTH_REG_W'(MAX_WIDTH);

  logic [WIDTH_REG_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic                    wr;
  fnmf_reg_t               sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = fnmf_reg_t'(paddr[2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr) begin
      case (sel)
        REG_WIDTH:  width_nxt  = pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[HEIGHT_REG_W-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (sel)
      REG_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  // out-of-range sizes clamp
  always_comb begin
    if (width_r < WIDTH_MIN) begin
      cfg.w_eff = WIDTH_MIN;
    end else if (width_r > WIDTH_MAX) begin
      cfg.w_eff = WIDTH_MAX;
    end else begin
      cfg.w_eff = width_r;
    end
    cfg.h_eff   = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;
    cfg.restart = wr;
  end

endmodule

// ----- hw/rtl/fnmf_ctrl.sv -----
module fnmf_ctrl
  import fnmf_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fnmf_cfg_t                         cfg,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              s1_free,
  output logic                              issue,
  output logic                              ram_we,
  output logic [$clog2(2*MAX_WIDTH)-1:0]    ram_waddr,
  output logic [$clog2(2*MAX_WIDTH)-1:0]    ram_raddr_a,
  output logic [$clog2(2*MAX_WIDTH)-1:0]    ram_raddr_b,
  output fnmf_tag_t                         tag
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(2*MAX_WIDTH);

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             bank_r, bank_nxt;
  logic             flush_r, flush_nxt;
  logic [CW-1:0]    fk_r, fk_nxt;
  logic             fbank_r, fbank_nxt;

  logic [WIDTH_REG_W-1:0] w_m1;
  logic [ROW_W-1:0]       h_m1;
  logic                   accept;
  logic                   flush_issue;
  logic                   cb;
  logic [CW-1:0]          cc;
  logic                   c_last;
  logic                   frame_end;
  logic [2:0]             n_terms;

  function automatic logic [AW-1:0] addr_of(input logic b, input logic [CW-1:0] c);
    logic [AW-1:0] base;
    base = b ? AW'(MAX_WIDTH) : '0;
    return base + AW'(c);
  endfunction

  assign w_m1        = cfg.w_eff - 6'd1;
  assign h_m1        = cfg.h_eff - 10'd1;
  assign in_tready   = s1_free && !flush_r;
  assign accept      = in_tvalid && in_tready;
  assign flush_issue = flush_r && s1_free;
  assign issue       = accept || flush_issue;

  // flush walks a virtual row below the frame with the banks swapped
  assign cb        = flush_r ? fbank_r : bank_r;
  assign cc        = flush_r ? fk_r : col_r;
  assign c_last    = (WIDTH_REG_W'(cc) == w_m1);
  assign frame_end = (row_r == h_m1) && c_last;

  assign ram_we      = accept;
  assign ram_waddr   = addr_of(bank_r, col_r);
  assign ram_raddr_a = addr_of(cb, cc);
  // right neighbour lookahead; at row end fetch column 0 of the row just written
  assign ram_raddr_b = c_last ? addr_of(cb, '0) : addr_of(!cb, cc + 1'b1);

  always_comb begin
    tag.emit      = flush_r || (row_r != '0);
    tag.last      = flush_r && c_last;
    tag.has_up    = flush_r || (row_r > 10'd1);
    tag.has_down  = !flush_r;
    tag.has_left  = (cc != '0);
    tag.has_right = !c_last;
    tag.row       = flush_r ? h_m1 : row_r - 10'd1;
    tag.col       = COL_OUT_W'(cc);
    n_terms = {2'b0, tag.has_up} + {2'b0, tag.has_down}
            + {2'b0, tag.has_left} + {2'b0, tag.has_right};
    case (n_terms)
      3'd4:    tag.div = DIV_4;
      3'd3:    tag.div = DIV_3;
      default: tag.div = DIV_2;
    endcase
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    bank_nxt  = bank_r;
    flush_nxt = flush_r;
    fk_nxt    = fk_r;
    fbank_nxt = fbank_r;
    if (cfg.restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      bank_nxt  = 1'b0;
      flush_nxt = 1'b0;
    end else begin
      if (accept) begin
        if (frame_end) begin
          col_nxt   = '0;
          row_nxt   = '0;
          bank_nxt  = 1'b0;
          flush_nxt = 1'b1;
          fk_nxt    = '0;
          fbank_nxt = !bank_r;
        end else if (c_last) begin
          col_nxt  = '0;
          row_nxt  = row_r + 10'd1;
          bank_nxt = !bank_r;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      if (flush_issue) begin
        if (c_last) begin
          flush_nxt = 1'b0;
        end else begin
          fk_nxt = fk_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      bank_r  <= 1'b0;
      flush_r <= 1'b0;
      fk_r    <= '0;
      fbank_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bank_r  <= bank_nxt;
      flush_r <= flush_nxt;
      fk_r    <= fk_nxt;
      fbank_r <= fbank_nxt;
    end
  end

  a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end && !cfg.restart) |=> flush_r)
    else $error("last word of frame did not start the row flush");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_issue && c_last && !cfg.restart) |=> !flush_r)
    else $error("row flush ran past the frame width");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (WIDTH_REG_W'(col_r) <= w_m1) && (row_r <= h_m1))
    else $error("raster position outside the frame");

endmodule

// ----- hw/rtl/fnmf_calc.sv -----
module fnmf_calc
  import fnmf_pkg::*;
#(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  fnmf_tag_t                     tag_in,
  input  logic signed [SAMPLE_BITS-1:0] up_data,
  input  logic signed [SAMPLE_BITS-1:0] right_data,
  output logic                          s1_free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_DATA_W-1:0]         out_tdata,
  output logic                          out_tlast
);

  localparam int SUMW  = SAMPLE_BITS + 2;
  localparam int K     = SAMPLE_BITS + 3;
  localparam int RECIP = (2**K + 2) / 3;
  localparam logic [K-1:0] RECIP_L = K'(RECIP);

  logic                          s1_v_r, s1_v_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_smp_r;
  fnmf_tag_t                     s1_tag_r;
  logic signed [SAMPLE_BITS-1:0] d1_r;
  logic signed [SAMPLE_BITS-1:0] d2_r;

  logic                 out_v_r, out_v_nxt;
  logic [SMOOTH_W-1:0]  out_smooth_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic                 out_last_r;

  logic                   out_can;
  logic                   out_load;
  logic signed [SUMW-1:0] t_down, t_up, t_left, t_right, sum;
  logic                   neg;
  logic [SUMW-1:0]        mag;
  logic [SUMW+K-1:0]      prod;
  logic [SUMW-1:0]        qa;
  logic signed [SUMW-1:0] q;
  logic [SUMW+SMOOTH_W-1:0] qx;

  assign out_can  = !out_v_r || out_tready;
  assign out_load = s1_v_r && s1_tag_r.emit && out_can;
  assign s1_free  = !s1_v_r || !s1_tag_r.emit || out_can;

  always_comb begin
    t_down  = s1_tag_r.has_down  ? SUMW'(s1_smp_r) : '0;
    t_up    = s1_tag_r.has_up    ? SUMW'(up_data)  : '0;
    t_left  = s1_tag_r.has_left  ? SUMW'(d2_r)     : '0;
    t_right = s1_tag_r.has_right ? SUMW'(right_data) : '0;
    sum     = t_down + t_up + t_left + t_right;
    neg     = sum[SUMW-1];
    mag     = neg ? -sum : sum;
    // divide by three through a scaled reciprocal, exact over the sum range
    prod    = mag * RECIP_L;
    case (s1_tag_r.div)
      DIV_4:   qa = mag >> 2;
      DIV_3:   qa = prod[SUMW+K-1:K];
      default: qa = mag >> 1;
    endcase
    q  = neg ? -qa : qa;
    qx = {{SMOOTH_W{q[SUMW-1]}}, q};
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (issue) begin
      s1_v_nxt = 1'b1;
    end else if (s1_free) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // left neighbour is the lookahead word from two items back
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_smp_r <= sample_in;
      s1_tag_r <= tag_in;
      d1_r     <= right_data;
      d2_r     <= d1_r;
    end
    if (out_load) begin
      out_smooth_r <= qx[SMOOTH_W-1:0];
      out_row_r    <= s1_tag_r.row;
      out_col_r    <= s1_tag_r.col;
      out_last_r   <= s1_tag_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_col_r, out_row_r, out_smooth_r};
  assign out_tlast  = out_last_r;

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_tag_r.emit && !out_can) |=> (s1_v_r && $stable(s1_tag_r)))
    else $error("pending result dropped while output stalled");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_v_r && out_last_r == $past(s1_tag_r.last)
                  && out_col_r == $past(s1_tag_r.col)))
    else $error("result register not loaded from stage one");

endmodule

// ----- hw/rtl/four_neighbour_mean_filter_top.sv -----
// throughput: one word per cycle while stage one is free and no row flush is running;
// results pass through one stage register and one output register
// the last word of a frame stops in_tready while the final row is read back from the
// two-bank line store, one column per cycle while stage one is free, through its two read ports
// reset: rst_n synchronous active low, clears position, flush and valid state, sets 5 x 5 size;
// the line store is not cleared
module four_neighbour_mean_filter_top
  import fnmf_pkg::*;
#(
  parameter int MAX_WIDTH   = 32,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // smoothed, out_row, out_col, zero pad
  output logic [OUT_DATA_W-1:0]                  out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]                  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                  cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int AW = $clog2(2*MAX_WIDTH);

  fnmf_cfg_t                     cfg;
  fnmf_tag_t                     tag;
  logic                          s1_free;
  logic                          issue;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr_a;
  logic [AW-1:0]                 ram_raddr_b;
  logic [SAMPLE_BITS-1:0]        rd_up;
  logic [SAMPLE_BITS-1:0]        rd_right;
  logic signed [SAMPLE_BITS-1:0] sample;

  assign sample = in_tdata[SAMPLE_BITS-1:0];

  fnmf_regs #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  fnmf_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .s1_free    (s1_free),
    .issue      (issue),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_raddr_a(ram_raddr_a),
    .ram_raddr_b(ram_raddr_b),
    .tag        (tag)
  );

  fnmf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(2*MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (sample),
    .re     (issue),
    .raddr_a(ram_raddr_a),
    .raddr_b(ram_raddr_b),
    .rdata_a(rd_up),
    .rdata_b(rd_right)
  );

  fnmf_calc #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .sample_in (sample),
    .tag_in    (tag),
    .up_data   (rd_up),
    .right_data(rd_right),
    .s1_free   (s1_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ----- dv/neighbour_mean_checker.sv -----
`timescale 1ns / 1ps

module neighbour_mean_checker
  import fnmf_pkg::*;
#(
  parameter int LINE_W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatch_count,
  output int                    pending_words,
  output int                    results_checked,
  output int                    frames_checked
);

  typedef struct packed {
    logic [SMOOTH_W-1:0]  smoothed;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } smoothed_word_t;

  smoothed_word_t expected_smoothed[$];

  // two row banks, one holding the current row and one the row above
  logic signed [7:0]       line_bank [2][LINE_W];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      col_pos;
  int                      row_pos;
  logic                    bank_sel;
  int                      fail_n = 0;
  int                      checked_n = 0;
  int                      frames_n = 0;

  task automatic expect_word(input int total, input int divisor, input int row,
                             input int col, input bit last);
    smoothed_word_t w_exp;
    int q;
    q = total / divisor;
    w_exp.smoothed = q[SMOOTH_W-1:0];
    w_exp.row = row[ROW_W-1:0];
    w_exp.col = col[COL_OUT_W-1:0];
    w_exp.last = last;
    expected_smoothed.push_back(w_exp);
  endtask

  task automatic predict_smoothed(input logic signed [7:0] s);
    int w;
    int h;
    int c;
    int r;
    int cur;
    int prv;
    int sum;
    int den;
    int k;
    logic signed [7:0] up;
    w = (width_reg < WIDTH_MIN) ? int'(WIDTH_MIN) :
        (width_reg > LINE_W) ? LINE_W : int'(width_reg);
    h = (height_reg < HEIGHT_MIN) ? int'(HEIGHT_MIN) : int'(height_reg);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    cur = int'(bank_sel);
    prv = cur ^ 1;
    up = line_bank[cur][c];
    line_bank[cur][c] = s;
    // each word of row r closes the position above it
    if (r > 0) begin
      sum = s;
      den = 1;
      if (r - 1 > 0) begin
        sum += up;
        den++;
      end
      if (c > 0) begin
        sum += line_bank[prv][c-1];
        den++;
      end
      if (c + 1 < w) begin
        sum += line_bank[prv][c+1];
        den++;
      end
      expect_word(sum, den, r - 1, c, 1'b0);
    end
    if (r == h - 1 && c == w - 1) begin
      // bottom row has no neighbour below
      for (k = 0; k < w; k++) begin
        sum = line_bank[prv][k];
        den = 1;
        if (k > 0) begin
          sum += line_bank[cur][k-1];
          den++;
        end
        if (k + 1 < w) begin
          sum += line_bank[cur][k+1];
          den++;
        end
        expect_word(sum, den, h - 1, k, k + 1 == w);
      end
      col_pos = 0;
      row_pos = 0;
      bank_sel = 1'b0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        bank_sel = prv[0];
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  task automatic check_word();
    smoothed_word_t exp_w;
    smoothed_word_t got;
    logic [OUT_PAD_W-1:0] pad;
    got.smoothed = out_tdata[SMOOTH_W-1:0];
    got.row = out_tdata[SMOOTH_W +: ROW_W];
    got.col = out_tdata[SMOOTH_W+ROW_W +: COL_OUT_W];
    got.last = out_tlast;
    pad = out_tdata[OUT_DATA_W-1 -: OUT_PAD_W];
    checked_n++;
    if (out_tlast) frames_n++;
    if (expected_smoothed.size() == 0) begin
      if (fail_n < 10)
        $display("%0t: unexpected word smoothed %0d row %0d col %0d last %0b", $realtime,
                 $signed(got.smoothed), got.row, got.col, got.last);
      fail_n++;
    end else begin
      exp_w = expected_smoothed.pop_front();
      if (got.smoothed !== exp_w.smoothed || got.row !== exp_w.row ||
          got.col !== exp_w.col || got.last !== exp_w.last || pad !== '0) begin
        if (fail_n < 10)
          $display("%0t: mismatch exp %0d row %0d col %0d last %0b, got %0d %0d %0d %0b pad %0h",
                   $realtime, $signed(exp_w.smoothed), exp_w.row, exp_w.col, exp_w.last,
                   $signed(got.smoothed), got.row, got.col, got.last, pad);
        fail_n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      bank_sel = 1'b0;
      expected_smoothed.delete();
    end else begin
      // any register write restarts the frame
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (fnmf_reg_t'(cfg_paddr[2]))
          REG_WIDTH:  width_reg = cfg_pwdata[WIDTH_REG_W-1:0];
          REG_HEIGHT: height_reg = cfg_pwdata[HEIGHT_REG_W-1:0];
          default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
        bank_sel = 1'b0;
      end
      if (in_tvalid && in_tready) predict_smoothed($signed(in_tdata));
      if (out_tvalid && out_tready) check_word();
    end
    mismatch_count <= fail_n;
    pending_words <= expected_smoothed.size();
    results_checked <= checked_n;
    frames_checked <= frames_n;
  end

endmodule

// ----- dv/tb_four_neighbour_mean_filter_top.sv -----
`timescale 1ns / 1ps

module tb_four_neighbour_mean_filter_top;
  import fnmf_pkg::*;

  localparam int MAX_W = 32;
  localparam int DRAIN = 8;
  localparam int TARGET_SAMPLES = 480;
  // directed 5 x 5 frame, listed from the last word down
  localparam logic [24:0][7:0] FIRST_FRAME = {
    8'h01, 8'hfe, 8'hff, 8'hff, 8'h00,
    8'h7f, 8'h80, 8'h7f, 8'h80, 8'h7f,
    8'hff, 8'h00, 8'hff, 8'h01, 8'hff,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // sample
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // smoothed, out_row, out_col, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int pending_words;
  int results_checked;
  int frames_checked;
  int samples_sent = 0;
  int settings_used = 0;
  int ready_hold = 0;
  bit ready_calm = 1'b0;

  four_neighbour_mean_filter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  neighbour_mean_checker #(.LINE_W(MAX_W)) smoothing_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .pending_words   (pending_words),
    .results_checked (results_checked),
    .frames_checked  (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL four_neighbour_mean_filter_top");
    $finish;
  end

  // output back-pressure, alternating calm and stalling stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) ready_calm <= !ready_calm;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (!ready_calm && $urandom_range(0, 99) < 30) begin
      ready_hold <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_sample();
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: return 8'h7f;
      1: return 8'h80;
      2: return 8'hff;
      3: return 8'h01;
      default: return 8'h00;
    endcase
  endfunction

  function automatic int phase_length(input int w_val, input int h_val);
    int ew;
    int eh;
    int size;
    ew = (w_val < 2) ? 2 : (w_val > MAX_W) ? MAX_W : w_val;
    eh = (h_val < 2) ? 2 : h_val;
    size = ew * eh;
    if (size <= 120 && $urandom_range(0, 3) != 0) return $urandom_range(1, 2) * size;
    // partial frame, cut off by the next register write
    return $urandom_range(1, (size - 1 < 3 * ew) ? size - 1 : 3 * ew);
  endfunction

  task automatic push_sample(input logic [7:0] s, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic write_reg(input fnmf_reg_t sel, input int val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic run_phase(input int w_val, input int h_val, input int count);
    bit gapless;
    write_reg(REG_WIDTH, w_val);
    write_reg(REG_HEIGHT, h_val);
    gapless = ($urandom_range(0, 3) == 0);
    repeat (count) push_sample(random_sample(), gapless ? 0 : pick_gap());
    in_tvalid <= 1'b0;
    settle();
    settings_used++;
  endtask

  initial begin
    int k;
    int w_val;
    int h_val;
    int r;
    int len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size, extreme values at corners, edges and interior
    for (k = 0; k < 25; k++) push_sample(FIRST_FRAME[k], pick_gap());
    in_tvalid <= 1'b0;
    settle();
    settings_used++;

    run_phase(2, 2, 8);
    run_phase(1, 0, 4);
    run_phase(63, 3, 96);
    run_phase(33, 1, 64);
    run_phase(7, 4, 13);
    run_phase(0, 1023, 10);
    run_phase(32, 1023, 45);

    while (samples_sent < TARGET_SAMPLES) begin
      r = $urandom_range(0, 99);
      if (r < 65) w_val = $urandom_range(2, 8);
      else if (r < 85) w_val = $urandom_range(9, 32);
      else begin
        case ($urandom_range(0, 4))
          0: w_val = 0;
          1: w_val = 1;
          2: w_val = 32;
          3: w_val = 33;
          default: w_val = 63;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 80) h_val = $urandom_range(2, 6);
      else if (r < 90) h_val = $urandom_range(0, 1);
      else h_val = $urandom_range(7, 1023);
      len = phase_length(w_val, h_val);
      if (len > TARGET_SAMPLES - samples_sent) len = TARGET_SAMPLES - samples_sent;
      run_phase(w_val, h_val, len);
    end

    settle();
    $display("sent %0d samples over %0d frame size settings", samples_sent, settings_used);
    $display("checked %0d smoothed words, %0d frame ends, %0d mismatches",
             results_checked, frames_checked, mismatch_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("PASS four_neighbour_mean_filter_top");
    end else begin
      $display("FAIL four_neighbour_mean_filter_top");
    end
    $finish;
  end

endmodule
